// ===== design/owbm_pkg.sv =====
package owbm_pkg;

  localparam int unsigned TIME_WIDTH_DEF = 10;

  localparam int unsigned CFG_NUM   = 8;
  localparam int unsigned CFG_IDX_W = 4;

  localparam int unsigned CFG_RESET_HIGH  = 0;
  localparam int unsigned CFG_RESET_LOW   = 1;
  localparam int unsigned CFG_PRES_WAIT   = 2;
  localparam int unsigned CFG_ZERO_LOW    = 3;
  localparam int unsigned CFG_ONE_LOW     = 4;
  localparam int unsigned CFG_SLOT        = 5;
  localparam int unsigned CFG_RECOVERY    = 6;
  localparam int unsigned CFG_READ_SAMPLE = 7;

  localparam int unsigned CFG_RESET_VAL [CFG_NUM] = '{480, 480, 60, 60, 1, 60, 1, 14};

  typedef enum logic [2:0] {
    KIND_TICK     = 3'd0,
    KIND_RESET    = 3'd1,
    KIND_WRITE    = 3'd2,
    KIND_RDBYTE   = 3'd3,
    KIND_RDBIT    = 3'd4,
    KIND_SHUTDOWN = 3'd5
  } kind_e;

  typedef enum logic [3:0] {
    PH_IDLE     = 4'd0,
    PH_RST_HIGH = 4'd1,
    PH_RST_LOW  = 4'd2,
    PH_RST_WAIT = 4'd3,
    PH_RST_REST = 4'd4,
    PH_WR_LOW   = 4'd5,
    PH_WR_REL   = 4'd6,
    PH_RD_LOW   = 4'd7,
    PH_RD_WAIT  = 4'd8,
    PH_RD_REST  = 4'd9
  } phase_e;

  typedef enum logic [1:0] {
    OP_RESET  = 2'd0,
    OP_WRITE  = 2'd1,
    OP_RDBYTE = 2'd2,
    OP_RDBIT  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    DRIVE_RELEASE = 2'd0,
    DRIVE_LOW     = 2'd1,
    DRIVE_HIGH    = 2'd2
  } drive_e;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] write_data;
    logic       line_level;
  } in_t;

  typedef struct packed {
    logic [1:0] line_drive;
    logic       busy_res;
    logic       done_res;
    logic       presence;
    logic [7:0] read_data;
    logic       rejected;
  } out_t;

endpackage

// ===== design/onewire_bus_master.sv =====
// Output: the result for an accepted item is presented in the cycle after acceptance.
// Throughput: one item per cycle while results are taken; each tick or command
// updates phase and wait counters in one pass, including chains of zero-length phases.
// Reset: asynchronous and active low; the bus master returns to idle with the line
// released, and the timing registers return to their default microsecond values.
module onewire_bus_master #(
  parameter int unsigned TimeWidth = owbm_pkg::TIME_WIDTH_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  owbm_pkg::in_t                  in_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output owbm_pkg::out_t                 out_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [owbm_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [TimeWidth-1:0]           cfg_data_i
);
  import owbm_pkg::*;

  logic [CFG_NUM-1:0][TimeWidth-1:0] cfg;
  logic accept;
  out_t res;
  out_t out_q;
  logic out_valid_q, out_valid_d;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign accept      = in_valid_i && in_ready_o;

  owbm_cfg #(
    .TimeWidth(TimeWidth)
  ) u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (cfg_valid_i && cfg_ready_o),
    .index_i (cfg_index_i),
    .data_i  (cfg_data_i),
    .cfg_o   (cfg)
  );

  owbm_core #(
    .TimeWidth(TimeWidth)
  ) u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .item_i   (in_i),
    .cfg_i    (cfg),
    .res_o    (res)
  );

  assign out_valid_d = accept || (out_valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  a_accept_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> out_valid_o)
    else $error("accepted item produced no result");

  a_idle_released: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_o.busy_res |-> out_o.line_drive == DRIVE_RELEASE)
    else $error("line driven while idle");

  a_done_not_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_o.done_res |-> !out_o.busy_res && !out_o.rejected)
    else $error("done reported with busy or rejected");

  a_reject_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_o.rejected |-> out_o.busy_res)
    else $error("rejection reported while idle");

endmodule

// ===== design/owbm_cfg.sv =====
module owbm_cfg #(
  parameter int unsigned TimeWidth = owbm_pkg::TIME_WIDTH_DEF
) (
  input  logic                                              clk_i,
  input  logic                                              rst_ni,
  input  logic                                              we_i,
  input  logic [owbm_pkg::CFG_IDX_W-1:0]                    index_i,
  input  logic [TimeWidth-1:0]                              data_i,
  output logic [owbm_pkg::CFG_NUM-1:0][TimeWidth-1:0]       cfg_o
);
  import owbm_pkg::*;

  logic [CFG_NUM-1:0][TimeWidth-1:0] cfg_q;

  for (genvar i = 0; i < CFG_NUM; i++) begin : g_reg
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        cfg_q[i] <= TimeWidth'(CFG_RESET_VAL[i]);
      end else if (we_i && index_i == CFG_IDX_W'(i)) begin
        cfg_q[i] <= data_i;
      end
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== design/owbm_core.sv =====
module owbm_core #(
  parameter int unsigned TimeWidth = owbm_pkg::TIME_WIDTH_DEF
) (
  input  logic                                         clk_i,
  input  logic                                         rst_ni,
  input  logic                                         accept_i,
  input  owbm_pkg::in_t                                item_i,
  input  logic [owbm_pkg::CFG_NUM-1:0][TimeWidth-1:0]  cfg_i,
  output owbm_pkg::out_t                               res_o
);
  import owbm_pkg::*;

  localparam int unsigned WW = TimeWidth + 1;
  localparam int unsigned SW = TimeWidth + 2;

  function automatic logic [WW-1:0] sat_time(logic [SW-1:0] s);
    return s[SW-1] ? '0 : s[WW-1:0];
  endfunction

  phase_e         phase_q, phase_d;
  logic [WW-1:0]  wait_q, wait_d;
  logic [2:0]     bit_q, bit_d;
  logic [7:0]     sd_q, sd_d;
  op_e            op_q, op_d;
  logic           pres_q, pres_d;

  logic [TimeWidth-1:0] rh, rl, pw, zl, ol, slot, rec, rs;
  logic [WW-1:0] w_rrest, w_rel1, w_rel0, w_rdrest, wdec;
  logic z_ol, z_zl, z_rs, z_rel1, z_rel0, z_rdrest, rd_allzero;
  logic line;

  assign rh   = cfg_i[CFG_RESET_HIGH];
  assign rl   = cfg_i[CFG_RESET_LOW];
  assign pw   = cfg_i[CFG_PRES_WAIT];
  assign zl   = cfg_i[CFG_ZERO_LOW];
  assign ol   = cfg_i[CFG_ONE_LOW];
  assign slot = cfg_i[CFG_SLOT];
  assign rec  = cfg_i[CFG_RECOVERY];
  assign rs   = cfg_i[CFG_READ_SAMPLE];

  assign w_rrest  = sat_time(SW'(rh) - SW'(pw));
  assign w_rel1   = sat_time(SW'(slot) - SW'(ol) + SW'(rec));
  assign w_rel0   = sat_time(SW'(slot) - SW'(zl) + SW'(rec));
  assign w_rdrest = sat_time(SW'(slot) - SW'(rs) - SW'(ol) + SW'(rec));

  assign z_ol       = (ol == '0);
  assign z_zl       = (zl == '0);
  assign z_rs       = (rs == '0);
  assign z_rel1     = (w_rel1 == '0);
  assign z_rel0     = (w_rel0 == '0);
  assign z_rdrest   = (w_rdrest == '0);
  assign rd_allzero = z_ol && z_rs && z_rdrest;

  assign line = item_i.line_level;
  assign wdec = (wait_q == '0) ? '0 : wait_q - WW'(1);

  // Reset and read phases: at most four phase ends per tick unless every
  // read phase has zero length, which is handled separately below.
  phase_e        ch_phase;
  logic [WW-1:0] ch_wait, step_wait;
  logic [2:0]    ch_bit;
  logic [7:0]    ch_sd;
  logic          ch_pres, ch_done, ch_stop;

  always_comb begin
    ch_phase  = phase_q;
    ch_bit    = bit_q;
    ch_sd     = sd_q;
    ch_pres   = pres_q;
    ch_wait   = '0;
    ch_done   = 1'b0;
    ch_stop   = 1'b0;
    step_wait = '0;
    for (int i = 0; i < 4; i++) begin
      if (!ch_stop) begin
        step_wait = '0;
        case (ch_phase)
          PH_RST_HIGH: begin
            ch_phase  = PH_RST_LOW;
            step_wait = WW'(rl);
          end
          PH_RST_LOW: begin
            ch_phase  = PH_RST_WAIT;
            step_wait = WW'(pw);
          end
          PH_RST_WAIT: begin
            ch_pres   = ~line;
            ch_phase  = PH_RST_REST;
            step_wait = w_rrest;
          end
          PH_RST_REST: begin
            ch_phase = PH_IDLE;
            ch_done  = 1'b1;
          end
          PH_RD_LOW: begin
            ch_phase  = PH_RD_WAIT;
            step_wait = WW'(rs);
          end
          PH_RD_WAIT: begin
            ch_sd     = (op_q == OP_RDBIT) ? {7'd0, line} : {line, ch_sd[7:1]};
            ch_phase  = PH_RD_REST;
            step_wait = w_rdrest;
          end
          PH_RD_REST: begin
            if (op_q == OP_RDBIT) begin
              ch_phase = PH_IDLE;
              ch_done  = 1'b1;
            end else begin
              ch_bit = ch_bit + 3'd1;
              if (ch_bit == 3'd0) begin
                ch_phase = PH_IDLE;
                ch_done  = 1'b1;
              end else begin
                ch_phase  = PH_RD_LOW;
                step_wait = WW'(ol);
              end
            end
          end
          default: begin
            ch_phase = PH_IDLE;
          end
        endcase
        if (ch_phase == PH_IDLE || step_wait != '0) begin
          ch_stop = 1'b1;
          ch_wait = step_wait;
        end
      end
    end
  end

  // All read phases of zero length: every remaining bit samples this tick's level.
  logic [3:0]  az_cnt;
  logic [15:0] az_shift;
  logic [7:0]  az_sd;
  logic        az_cur;

  always_comb begin
    az_cur   = (phase_q != PH_RD_REST);
    az_cnt   = 4'(3'd7 - bit_q) + {3'd0, az_cur};
    az_shift = {{8{line}}, sd_q} >> az_cnt;
    if (op_q == OP_RDBIT) begin
      az_sd = az_cur ? {7'd0, line} : sd_q;
    end else begin
      az_sd = az_shift[7:0];
    end
  end

  // Write: a bit passes entirely in one tick when both its low and release
  // times are zero, so the stop point is the first bit that does not pass.
  phase_e        wr_phase;
  logic [WW-1:0] wr_wait;
  logic [2:0]    wr_bit, wr_j;
  logic [7:0]    wr_sd;
  logic          wr_done, wr_hit, wr_nb;

  always_comb begin
    wr_hit = 1'b0;
    wr_j   = '0;
    for (int j = 1; j < 8; j++) begin
      if (!wr_hit && (3'(j) <= 3'd7 - bit_q) &&
          !((sd_q[j] ? z_ol : z_zl) && (sd_q[j] ? z_rel1 : z_rel0))) begin
        wr_hit = 1'b1;
        wr_j   = 3'(j);
      end
    end
    wr_nb   = sd_q[wr_j];
    wr_done = 1'b0;
    if (phase_q == PH_WR_LOW && !(sd_q[0] ? z_rel1 : z_rel0)) begin
      wr_phase = PH_WR_REL;
      wr_wait  = sd_q[0] ? w_rel1 : w_rel0;
      wr_sd    = sd_q;
      wr_bit   = bit_q;
    end else if (wr_hit) begin
      wr_sd  = sd_q >> wr_j;
      wr_bit = bit_q + wr_j;
      if (!(wr_nb ? z_ol : z_zl)) begin
        wr_phase = PH_WR_LOW;
        wr_wait  = wr_nb ? WW'(ol) : WW'(zl);
      end else begin
        wr_phase = PH_WR_REL;
        wr_wait  = wr_nb ? w_rel1 : w_rel0;
      end
    end else begin
      wr_phase = PH_IDLE;
      wr_wait  = '0;
      wr_sd    = sd_q >> (4'd8 - {1'b0, bit_q});
      wr_bit   = '0;
      wr_done  = 1'b1;
    end
  end

  logic done, rej;

  always_comb begin
    phase_d = phase_q;
    wait_d  = wait_q;
    bit_d   = bit_q;
    sd_d    = sd_q;
    op_d    = op_q;
    pres_d  = pres_q;
    done    = 1'b0;
    rej     = 1'b0;
    case (item_i.kind)
      KIND_TICK: begin
        if (phase_q != PH_IDLE) begin
          if (wdec != '0) begin
            wait_d = wdec;
          end else if (phase_q == PH_WR_LOW || phase_q == PH_WR_REL) begin
            phase_d = wr_phase;
            wait_d  = wr_wait;
            bit_d   = wr_bit;
            sd_d    = wr_sd;
            done    = wr_done;
          end else if (rd_allzero && (phase_q == PH_RD_LOW || phase_q == PH_RD_WAIT ||
                                      phase_q == PH_RD_REST)) begin
            phase_d = PH_IDLE;
            wait_d  = '0;
            bit_d   = (op_q == OP_RDBIT) ? bit_q : 3'd0;
            sd_d    = az_sd;
            done    = 1'b1;
          end else begin
            phase_d = ch_phase;
            wait_d  = ch_wait;
            bit_d   = ch_bit;
            sd_d    = ch_sd;
            pres_d  = ch_pres;
            done    = ch_done;
          end
        end
      end
      KIND_RESET, KIND_WRITE, KIND_RDBYTE, KIND_RDBIT: begin
        if (phase_q != PH_IDLE) begin
          rej = 1'b1;
        end else begin
          bit_d = '0;
          case (item_i.kind)
            KIND_RESET: begin
              op_d    = OP_RESET;
              pres_d  = 1'b0;
              phase_d = PH_RST_HIGH;
              wait_d  = WW'(rh);
            end
            KIND_WRITE: begin
              op_d    = OP_WRITE;
              sd_d    = item_i.write_data;
              phase_d = PH_WR_LOW;
              wait_d  = item_i.write_data[0] ? WW'(ol) : WW'(zl);
            end
            default: begin
              op_d    = (item_i.kind == KIND_RDBYTE) ? OP_RDBYTE : OP_RDBIT;
              sd_d    = '0;
              phase_d = PH_RD_LOW;
              wait_d  = WW'(ol);
            end
          endcase
        end
      end
      KIND_SHUTDOWN: begin
        phase_d = PH_IDLE;
        wait_d  = '0;
        bit_d   = '0;
        done    = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    case (phase_d)
      PH_RST_HIGH:                      res_o.line_drive = DRIVE_HIGH;
      PH_RST_LOW, PH_WR_LOW, PH_RD_LOW: res_o.line_drive = DRIVE_LOW;
      default:                          res_o.line_drive = DRIVE_RELEASE;
    endcase
    res_o.busy_res  = (phase_d != PH_IDLE);
    res_o.done_res  = done;
    res_o.rejected  = rej;
    res_o.presence  = (done && item_i.kind == KIND_TICK && op_q == OP_RESET) ? pres_d : 1'b0;
    res_o.read_data = (done && item_i.kind == KIND_TICK &&
                       (op_q == OP_RDBYTE || op_q == OP_RDBIT)) ? sd_d : 8'd0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      wait_q  <= '0;
      bit_q   <= '0;
      sd_q    <= '0;
      op_q    <= OP_RESET;
      pres_q  <= 1'b0;
    end else if (accept_i) begin
      phase_q <= phase_d;
      wait_q  <= wait_d;
      bit_q   <= bit_d;
      sd_q    <= sd_d;
      op_q    <= op_d;
      pres_q  <= pres_d;
    end
  end

  a_idle_no_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_IDLE |-> wait_q == '0)
    else $error("wait count left while idle");

  a_idle_bit_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_IDLE |-> bit_q == 3'd0)
    else $error("bit index left while idle");

  a_shutdown_idles: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && item_i.kind == KIND_SHUTDOWN |=> phase_q == PH_IDLE && bit_q == 3'd0)
    else $error("shutdown did not return to idle");

endmodule
